FILE: sv/sdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types and constants of the scaled integer dot product row unit.
// ----------------------------------------------------------------------------
package sdp_pkg;

   localparam int MAX_WORDS = 32;                    // left vector depth, 1..32 (5-bit word_index)
   localparam int ADDR_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int IDX_W     = 5;                     // word_index field width
   localparam int WORD_W    = 64;                    // packed word width
   localparam int LANE_W    = 16;                    // widest lane element
   localparam int LANES     = WORD_W / LANE_W;       // multiplier lanes
   localparam int SUM_W     = 32;
   localparam int SCALE_W   = 32;
   localparam int VALUE_W   = 64;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DATA_W = 104;                  // 101 field bits, byte padded
   localparam int RSP_DATA_W = 96;

   typedef enum logic {
      MODE_INT8  = 1'b0,
      MODE_INT16 = 1'b1
   } mode_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_ROW  = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ELEMENT_MODE = 1'b0,
      REG_LEFT_SCALE   = 1'b1
   } reg_index_type;

   typedef logic signed [SUM_W-1:0] part_type;

   typedef struct packed {
      logic en;     // add this word's lane results
      logic last;   // close the row: publish the sum and clear
   } merge_ctl_type;

   typedef struct packed {
      logic prod_en;   // register left_scale * column_scale
      logic round_en;  // register rounded, saturated scale
   } scale_ctl_type;

endpackage

FILE: sv/scaled_int_dot_product_row_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_int_dot_product_row_unit
// Quantized int8/int16 dot product of one right-hand row against a stored
// left vector, with Q8.24 dequantization of each finished row.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------
//  req     | in  | req_tvalid/tready   | tuser=kind, tlast=last_word, tdata
//  rsp     | out | rsp_tvalid/tready   | tuser=column_skipped, tdata
//  csr     | in  | csr_we (no wait)    | csr_index, csr_wdata
//
//  Steps: a load request is written straight into the word RAM when it is
//  accepted. A row word passes through RAM read, lane multiply and
//  accumulate. The last word of a row adds the scale multiply and the
//  round/saturate step, and waits while the result slot stays full.
//  The registered RAM read and the two 32x32 multipliers set these steps.
//  Reset clears the control state, the running sum and the registers
//  (element_mode = int8 lanes, left_scale = 1.0). A stalled rsp request
//  holds in the output register; the block still takes new requests
//  and only waits once another result is ready to be posted.
// ----------------------------------------------------------------------------
module scaled_int_dot_product_row_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: word_index[4:0], packed_word[68:5], column_scale[100:69], zero pad
   input  logic [sdp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: kind
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: dot_sum[31:0], scaled_value[95:32]
   output logic [sdp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: column_skipped
   output logic                                rsp_tuser,
   // register write port
   input  logic                                csr_we,
   input  logic [sdp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sdp_pkg::SCALE_W-1:0]         csr_wdata
);
   import sdp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,   // take requests
      ST_READ  = 5'b00010,   // left word out of RAM, lanes multiply
      ST_ACC   = 5'b00100,   // merge lanes into the running sum
      ST_ROUND = 5'b01000,   // round and saturate the combined scale
      ST_OUT   = 5'b10000    // post the result once the slot is free
   } state_type;

   state_type state_ff;
   state_type state_in;

   // request fields
   logic [IDX_W-1:0]          req_index;
   logic [WORD_W-1:0]         req_word;
   logic signed [SCALE_W-1:0] req_cscale;
   logic                      req_fire;
   logic                      idx_ok;

   // configuration
   mode_type                  mode_ff;
   logic signed [SCALE_W-1:0] lscale_ff;

   // captured row request
   logic [WORD_W-1:0]         word_ff;
   logic signed [SCALE_W-1:0] cscale_ff;
   logic                      last_ff;
   logic                      idx_ok_ff;

   // datapath
   logic                      ram_we;
   logic                      ram_re;
   logic [WORD_W-1:0]         ram_rdata;
   logic [WORD_W-1:0]         left_word;
   part_type                  parts [LANES];
   part_type                  dot_sum;
   merge_ctl_type             merge_ctl;
   scale_ctl_type             scale_ctl;
   logic signed [VALUE_W-1:0] scaled_value;
   logic                      skipped;

   // output slot
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      out_load;
   logic                      out_free;
   part_type                  out_dot_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      out_skip_ff;

   assign req_index  = req_tdata[IDX_W-1:0];
   assign req_word   = req_tdata[IDX_W +: WORD_W];
   assign req_cscale = req_tdata[IDX_W+WORD_W +: SCALE_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign idx_ok     = (32'(req_index) < MAX_WORDS);

   // loads write at acceptance, row words start a read; out-of-range loads drop
   assign ram_we = req_fire && (req_tuser == KIND_LOAD) && idx_ok;
   assign ram_re = req_fire && (req_tuser == KIND_ROW);

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_INT8;
         lscale_ff <= 32'sd16777216;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_ELEMENT_MODE: mode_ff   <= mode_type'(csr_wdata[0]);
            REG_LEFT_SCALE:   lscale_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // ------------------------------------------------------------ word store
   sdp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WORDS)
   ) u_left_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ADDR_W'(req_index)),
      .wdata (req_word),
      .rdata (ram_rdata)
   );

   // hold the row request while it moves through the stages
   always_ff @(posedge clock) begin
      if (ram_re) begin
         word_ff   <= req_word;
         cscale_ff <= req_cscale;
         last_ff   <= req_tlast;
         idx_ok_ff <= idx_ok;
      end
   end

   // an index past the store multiplies by a zero word
   assign left_word = idx_ok_ff ? ram_rdata : '0;

   // ----------------------------------------------------------------- lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      sdp_lane u_lane (
         .clock (clock),
         .en    (state_ff == ST_READ),
         .mode  (mode_ff),
         .a     (left_word[g*LANE_W +: LANE_W]),
         .b     (word_ff[g*LANE_W +: LANE_W]),
         .part  (parts[g])
      );
   end

   assign merge_ctl.en   = (state_ff == ST_ACC);
   assign merge_ctl.last = last_ff;

   sdp_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .ctl     (merge_ctl),
      .parts   (parts),
      .dot_sum (dot_sum)
   );

   // start the scale product alongside the final accumulate
   assign scale_ctl.prod_en  = (state_ff == ST_ACC) && last_ff;
   assign scale_ctl.round_en = (state_ff == ST_ROUND);

   sdp_scale u_scale (
      .clock        (clock),
      .ctl          (scale_ctl),
      .left_scale   (lscale_ff),
      .column_scale (cscale_ff),
      .dot_sum      (dot_sum),
      .scaled_value (scaled_value),
      .skipped      (skipped)
   );

   // ------------------------------------------------------------- sequencer
   assign out_free = !out_valid_ff || rsp_tready;
   assign out_load = (state_ff == ST_OUT) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (ram_re) begin
            state_in = ST_READ;
         end
         ST_READ:  state_in = ST_ACC;
         ST_ACC:   state_in = last_ff ? ST_ROUND : ST_IDLE;
         ST_ROUND: state_in = ST_OUT;
         ST_OUT:   if (out_free) begin
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ----------------------------------------------------------- output slot
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // a zero scale drops the sum; the product is zero already
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_dot_ff   <= skipped ? '0 : dot_sum;
         out_value_ff <= scaled_value;
         out_skip_ff  <= skipped;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_value_ff, out_dot_ff};
   assign rsp_tuser  = out_skip_ff;

endmodule

FILE: sv/sdp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sdp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/sdp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_lane
// One 16-bit multiplier lane: one int16 product or the sum of two int8
// products, registered.
// ----------------------------------------------------------------------------
module sdp_lane (
   input  logic                        clock,
   input  logic                        en,
   input  sdp_pkg::mode_type           mode,
   input  logic [sdp_pkg::LANE_W-1:0]  a,
   input  logic [sdp_pkg::LANE_W-1:0]  b,
   output sdp_pkg::part_type           part
);
   import sdp_pkg::*;

   logic signed [2*LANE_W-1:0] p16;
   logic signed [LANE_W-1:0]   p_lo;
   logic signed [LANE_W-1:0]   p_hi;
   part_type                   part_in;
   part_type                   part_ff;

   assign p16  = $signed(a) * $signed(b);
   assign p_lo = $signed(a[7:0]) * $signed(b[7:0]);
   assign p_hi = $signed(a[15:8]) * $signed(b[15:8]);

   always_comb begin
      unique case (mode)
         MODE_INT16: part_in = p16;
         MODE_INT8:  part_in = {{(SUM_W-LANE_W){p_lo[LANE_W-1]}}, p_lo}
                             + {{(SUM_W-LANE_W){p_hi[LANE_W-1]}}, p_hi};
         default:    part_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         part_ff <= part_in;
      end
   end

   assign part = part_ff;

endmodule

FILE: sv/sdp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_merge
// Merge the lane results into the wrapping running sum of a row.
// ----------------------------------------------------------------------------
module sdp_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  sdp_pkg::merge_ctl_type  ctl,
   input  sdp_pkg::part_type       parts [sdp_pkg::LANES],
   output sdp_pkg::part_type       dot_sum
);
   import sdp_pkg::*;

   part_type run_ff;
   part_type run_in;
   part_type dot_ff;
   part_type total;

   always_comb begin
      total = run_ff;
      for (int i = 0; i < LANES; i++) begin
         total = total + parts[i];   // wraps at 32 bits
      end
   end

   always_comb begin
      run_in = run_ff;
      if (ctl.en) begin
         run_in = ctl.last ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en && ctl.last) begin
         dot_ff <= total;
      end
   end

   assign dot_sum = dot_ff;

endmodule

FILE: sv/sdp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_scale
// Combined Q8.24 scale (round half up, saturate) and dequantized product.
// ----------------------------------------------------------------------------
module sdp_scale (
   input  logic                              clock,
   input  sdp_pkg::scale_ctl_type            ctl,
   input  logic signed [sdp_pkg::SCALE_W-1:0] left_scale,
   input  logic signed [sdp_pkg::SCALE_W-1:0] column_scale,
   input  sdp_pkg::part_type                 dot_sum,
   output logic signed [sdp_pkg::VALUE_W-1:0] scaled_value,
   output logic                              skipped
);
   import sdp_pkg::*;

   localparam int RND_W = 2*SCALE_W - 24;
   localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(64'sh7FFF_FFFF);
   localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(64'sh8000_0000);

   logic signed [2*SCALE_W-1:0] prod_ff;
   logic signed [2*SCALE_W-1:0] biased;
   logic signed [RND_W-1:0]     rounded;
   logic signed [SCALE_W-1:0]   scale_in;
   logic signed [SCALE_W-1:0]   scale_ff;

   // floor((p + 2^23) / 2^24): arithmetic shift gives floor for either sign
   assign biased  = prod_ff + (2*SCALE_W)'(64'sd8388608);
   assign rounded = RND_W'(biased >>> 24);

   always_comb begin
      priority if (rounded > SAT_MAX) begin
         scale_in = SCALE_W'(SAT_MAX);
      end else if (rounded < SAT_MIN) begin
         scale_in = SCALE_W'(SAT_MIN);
      end else begin
         scale_in = SCALE_W'(rounded);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= left_scale * column_scale;
      end
      if (ctl.round_en) begin
         scale_ff <= scale_in;
      end
   end

   assign scaled_value = (2*SCALE_W)'(scale_ff) * (2*SCALE_W)'(dot_sum);
   assign skipped      = (scale_ff == '0);

endmodule

FILE: sim/dot_row_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_row_check_pkg
// Result prediction and checking for the scaled integer dot product row unit.
// ----------------------------------------------------------------------------
package dot_row_check_pkg;

   import sdp_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0]   dot_sum;
      logic [VALUE_W-1:0] scaled_value;
      logic               column_skipped;
   } row_result_t;

   class dot_row_scoreboard;
      logic [WORD_W-1:0]  left_words [MAX_WORDS];
      logic [SUM_W-1:0]   row_sum;
      mode_type           lane_mode;
      logic [SCALE_W-1:0] left_scale;
      row_result_t        pending_rows [$];
      int                 requests_seen;
      int                 results_checked;
      int                 mismatches;

      function new();
         foreach (left_words[i]) left_words[i] = '0;
         row_sum         = '0;
         lane_mode       = MODE_INT8;
         left_scale      = 32'h0100_0000;
         requests_seen   = 0;
         results_checked = 0;
         mismatches      = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [SCALE_W-1:0] data);
         case (idx)
            REG_ELEMENT_MODE: lane_mode = mode_type'(data[0]);
            REG_LEFT_SCALE:   left_scale = data;
            default: ;
         endcase
      endfunction

      // Exact lane products of one word pair, summed modulo 2^32.
      function logic [SUM_W-1:0] lane_sum(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
         logic signed [31:0] pa;
         logic signed [31:0] pb;
         logic [31:0]        acc;
         int                 i;
         acc = '0;
         if (lane_mode == MODE_INT16) begin
            for (i = 0; i < 4; i++) begin
               pa  = $signed(a[16*i +: 16]);
               pb  = $signed(b[16*i +: 16]);
               acc = acc + pa * pb;
            end
         end else begin
            for (i = 0; i < 8; i++) begin
               pa  = $signed(a[8*i +: 8]);
               pb  = $signed(b[8*i +: 8]);
               acc = acc + pa * pb;
            end
         end
         return acc;
      endfunction

      // Q8.24 x Q8.24, round half up back to Q8.24, clamp to 32 bits.
      function logic signed [SCALE_W-1:0] combined_scale(logic signed [SCALE_W-1:0] ls,
                                                         logic signed [SCALE_W-1:0] cs);
         logic signed [63:0] wl;
         logic signed [63:0] wc;
         logic signed [63:0] q;
         logic signed [63:0] r;
         wl = ls;
         wc = cs;
         q  = wl * wc + 64'sd8388608;
         r  = q >>> 24;
         if (r > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
         else if (r < -64'sd2147483648)
            return 32'sh8000_0000;
         return r[31:0];
      endfunction

      function void note_request(kind_type kind, logic [IDX_W-1:0] idx,
                                 logic [WORD_W-1:0] word, logic [SCALE_W-1:0] cs,
                                 logic last);
         row_result_t        res;
         logic signed [31:0] scale;
         logic signed [63:0] wscale;
         logic signed [63:0] wdot;
         requests_seen++;
         if (kind == KIND_LOAD) begin
            if (idx < MAX_WORDS) left_words[idx] = word;
            return;
         end
         row_sum = row_sum + lane_sum((idx < MAX_WORDS) ? left_words[idx] : 64'd0, word);
         if (!last) return;
         scale = combined_scale(left_scale, cs);
         if (scale == 0) begin
            res.dot_sum        = '0;
            res.scaled_value   = '0;
            res.column_skipped = 1'b1;
         end else begin
            wscale             = scale;
            wdot               = $signed(row_sum);
            res.dot_sum        = row_sum;
            res.scaled_value   = wscale * wdot;
            res.column_skipped = 1'b0;
         end
         row_sum = '0;
         pending_rows.push_back(res);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic skipped);
         row_result_t exp_row;
         if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: dot_sum=%0d scaled_value=%0d skipped=%b",
                        $signed(data[31:0]), $signed(data[95:32]), skipped);
            return;
         end
         exp_row = pending_rows.pop_front();
         results_checked++;
         if (data[31:0] !== exp_row.dot_sum || data[95:32] !== exp_row.scaled_value ||
             skipped !== exp_row.column_skipped) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d mismatch: expected dot_sum=%0d scaled_value=%0d skipped=%b",
                        results_checked, $signed(exp_row.dot_sum),
                        $signed(exp_row.scaled_value), exp_row.column_skipped);
               $display("   got dot_sum=%0d scaled_value=%0d skipped=%b",
                        $signed(data[31:0]), $signed(data[95:32]), skipped);
            end
         end
      endfunction

      function int pending();
         return pending_rows.size();
      endfunction
   endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scaled integer dot product row unit: directed
// corner requests, then randomized loads and row sequences under changing
// lane modes, scales and back-pressure, checked against a built-in predictor.
// ----------------------------------------------------------------------------
module tb_top;

   import sdp_pkg::*;
   import dot_row_check_pkg::*;

   localparam int STALL_LIMIT   = 5000;   // cycles without any handshake
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 150;
   localparam int SETTLE_CYCLES = 8;      // row word pipeline depth plus margin

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SCALE_W-1:0]    csr_wdata  = '0;

   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    stall_cycles  = 0;
   int                    config_writes = 0;
   dot_row_scoreboard     sb;

   scaled_int_dot_product_row_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Randomly stall the response side at the current idle rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Sample both channels with pre-edge values. Check the response first so
   // a request accepted on the same edge can never satisfy it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            sb.note_request(kind_type'(req_tuser), req_tdata[4:0], req_tdata[68:5],
                            req_tdata[100:69], req_tlast);
      end
   end

   // Count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending());
      $display("[scaled_int_dot_product_row_unit] ERROR");
      $finish;
   end

   // Mostly Q8.24 values of moderate size, plus the extremes and zero.
   function automatic logic [SCALE_W-1:0] rand_scale();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0100_0000;
               3:       return 32'hFF00_0000;
               default: return 32'h0000_0001;
            endcase
         end
         1:       return '0;
         default: return $signed($urandom) >>> $urandom_range(0, 31);
      endcase
   endfunction

   // Random packed lanes, with the all-minimum and all-maximum patterns mixed in.
   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 64'h8080_8080_8080_8080;
         1: return 64'h8000_8000_8000_8000;
         2: return 64'h7F7F_7F7F_7F7F_7F7F;
         3: return 64'h7FFF_7FFF_7FFF_7FFF;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Present one request, optionally after random idle cycles, and hold it
   // until the block takes it. Valid stays high into the next request.
   task automatic send_request(kind_type kind, logic [IDX_W-1:0] idx,
                               logic [WORD_W-1:0] word, logic [SCALE_W-1:0] cs,
                               logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {3'b000, cs, word, idx};
      do begin
         @(posedge clock);
      end while (!(req_tvalid && req_tready));
   endtask

   // Loads carry random last and scale bits; the block must ignore both.
   task automatic load_random(logic [IDX_W-1:0] idx);
      send_request(KIND_LOAD, idx, rand_word(), rand_scale(), 1'($urandom));
   endtask

   // Drop valid, wait for every expected result, then let in-flight row
   // words that produce no result clear the pipeline.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [SCALE_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      sb.write_reg(idx, data);
      config_writes++;
   endtask

   initial begin
      int                 seg;
      int                 sent;
      int                 pick;
      int                 len;
      int                 k;
      logic [IDX_W-1:0]   base;
      logic [SCALE_W-1:0] ls;

      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part: reset registers first (int8, scale 1.0) ----
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(KIND_LOAD, 5'd0,  64'h8080_8080_8080_8080, 32'h0, 1'b1);
      send_request(KIND_LOAD, 5'd1,  64'h7F7F_7F7F_7F7F_7F7F, 32'hFFFF_FFFF, 1'b0);
      send_request(KIND_LOAD, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
      send_request(KIND_LOAD, 5'd2,  64'h0, 32'h0, 1'b0);
      send_request(KIND_LOAD, 5'd3,  64'h8000_8000_8000_8000, 32'h0, 1'b0);
      // -128 * -128 in every lane: must stay exact, no pair saturation
      send_request(KIND_ROW, 5'd0,  64'h8080_8080_8080_8080, 32'h0100_0000, 1'b1);
      // two-word row ending on the top index, negative unit scale
      send_request(KIND_ROW, 5'd1,  64'h8080_8080_8080_8080, 32'h1234_5678, 1'b0);
      send_request(KIND_ROW, 5'd31, 64'h7F7F_7F7F_7F7F_7F7F, 32'hFF00_0000, 1'b1);
      // zero column scale: sum is skipped
      send_request(KIND_ROW, 5'd2,  {$urandom, $urandom}, 32'h0, 1'b1);
      send_request(KIND_ROW, 5'd0,  64'h7F7F_7F7F_7F7F_7F7F, 32'h7FFF_FFFF, 1'b1);
      send_request(KIND_ROW, 5'd1,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0001, 1'b1);
      drain_block();

      // int16 lanes with the most negative left scale: saturate both ways
      write_csr(REG_ELEMENT_MODE, 32'(MODE_INT16));
      write_csr(REG_LEFT_SCALE, 32'h8000_0000);
      // four -32768^2 products wrap the accumulator to exactly zero
      send_request(KIND_ROW, 5'd3, 64'h8000_8000_8000_8000, 32'h8000_0000, 1'b1);
      send_request(KIND_ROW, 5'd1, 64'h7FFF_7FFF_7FFF_7FFF, 32'h7FFF_FFFF, 1'b1);
      // leave a row open across the mode change
      send_request(KIND_ROW, 5'd0, 64'h8000_8000_8000_8000, 32'h0000_0001, 1'b0);
      drain_block();

      write_csr(REG_ELEMENT_MODE, 32'(MODE_INT8));
      write_csr(REG_LEFT_SCALE, 32'h0000_0001);
      // close the open row in int8 mode; 1 x 1.0 rounds to scale 1
      send_request(KIND_ROW, 5'd31, 64'h8080_8080_8080_8080, 32'h0100_0000, 1'b1);
      // rounding: below half -> zero, exactly half -> up, minus half -> zero
      send_request(KIND_ROW, 5'd0, 64'h8080_8080_8080_8080, 32'h0040_0000, 1'b1);
      send_request(KIND_ROW, 5'd0, 64'h8080_8080_8080_8080, 32'h0080_0000, 1'b1);
      send_request(KIND_ROW, 5'd1, 64'h7F7F_7F7F_7F7F_7F7F, 32'hFF80_0000, 1'b1);
      send_request(KIND_ROW, 5'd1, 64'h8080_8080_8080_8080, 32'hFF7F_FFFF, 1'b1);

      // ---- random part: segments with fresh register settings ----
      for (seg = 0; seg < SEGMENTS; seg++) begin
         // switch idle profile at each third of the run
         if (seg == 0) begin
            send_idle_pct = 33;
            recv_idle_pct = 74;
         end else if (seg == SEGMENTS / 3) begin
            send_idle_pct = 74;
            recv_idle_pct = 33;
         end else if (seg == 2 * SEGMENTS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain_block();
         case (seg)
            0:       ls = 32'h7FFF_FFFF;
            1:       ls = 32'h8000_0000;
            2:       ls = '0;
            3:       ls = 32'h0100_0000;
            default: ls = rand_scale();
         endcase
         write_csr(REG_ELEMENT_MODE, 32'(seg % 2));
         write_csr(REG_LEFT_SCALE, ls);

         // fill the whole store once so every index is safe to read
         if (seg == 0) begin
            for (k = 0; k < MAX_WORDS; k++) load_random(IDX_W'(k));
         end

         sent = 0;
         while (sent < SEGMENT_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               load_random(IDX_W'($urandom));
               sent++;
            end else if (pick < 88) begin
               // well-formed row: consecutive words, last on the final one;
               // now and then a load slips in between
               len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_WORDS)
                                                  : $urandom_range(1, 8);
               base = IDX_W'($urandom);
               for (k = 0; k < len; k++) begin
                  if ($urandom_range(0, 29) == 0) begin
                     load_random(IDX_W'($urandom));
                     sent++;
                  end
                  send_request(KIND_ROW, base + IDX_W'(k), rand_word(), rand_scale(),
                               k == len - 1);
                  sent++;
               end
            end else begin
               // stray row word at any index, last at random
               send_request(KIND_ROW, IDX_W'($urandom), rand_word(), rand_scale(),
                            1'($urandom));
               sent++;
            end
         end
      end

      // ---- wind down: collect every result, then let the pipeline settle ----
      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests and %0d checked results over %0d register writes,",
               sb.requests_seen, sb.results_checked, config_writes);
      $display("both lane modes and three idle profiles; %0d mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[scaled_int_dot_product_row_unit] OK");
      else
         $display("[scaled_int_dot_product_row_unit] ERROR");
      $finish;
   end

endmodule
